// File: hdl/ccov_pkg.sv
// shared types, widths and divider step functions for the capsule overlap pipeline
package ccov_pkg;

  localparam int CW    = 32;          // coordinate width
  localparam int RW    = 31;          // radius width
  localparam int PB    = 16;          // segment parameter fraction bits
  localparam int QW    = PB + 1;      // parameter width, 0 .. 1.0
  localparam int DW    = CW + 1;      // axis and offset difference width
  localparam int PRW   = 2 * DW;      // one dot product term
  localparam int DOTW  = PRW + 3;     // dot product sum
  localparam int PW    = 2 * DOTW;    // products of dot products
  localparam int RSW   = RW + 1;      // summed radii
  localparam int DVW   = DW + QW + 1; // closest point difference component
  localparam int SUMW  = 2 * DVW + 2; // squared distance
  localparam int GW    = 63;          // reported squared distance
  localparam int GAP_LSB = 2 * PB;
  localparam int MLN   = 3;           // limbs per wide multiplier operand
  localparam int ML    = DOTW / MLN;  // limb width

  localparam logic [QW-1:0] PARAM_ONE = {1'b1, {PB{1'b0}}};

  localparam logic [2:0] REG_OWN_START_X = 3'd0;
  localparam logic [2:0] REG_OWN_START_Y = 3'd1;
  localparam logic [2:0] REG_OWN_START_Z = 3'd2;
  localparam logic [2:0] REG_OWN_END_X   = 3'd3;
  localparam logic [2:0] REG_OWN_END_Y   = 3'd4;
  localparam logic [2:0] REG_OWN_END_Z   = 3'd5;
  localparam logic [2:0] REG_OWN_RADIUS  = 3'd6;

  typedef logic signed [DW-1:0]   diff_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [PW-1:0]   wide_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    point_t          start_p;
    point_t          end_p;
    logic [RW-1:0]   radius;
  } capsule_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } dvec_t;

  typedef struct packed {
    dvec_t           d1;
    dvec_t           d2;
    dvec_t           rv;
    logic [RSW-1:0]  rsum;
  } geo_t;

  typedef struct packed {
    dot_t a;
    dot_t e;
    dot_t b;
    dot_t c;
    dot_t f;
  } coef_t;

  typedef struct packed {
    logic [PW:0]    rem;
    logic [PW-1:0]  den;
    logic [QW-1:0]  q;
    logic           done;
  } div_t;

  typedef struct packed {
    logic           overlap;
    logic [GW-1:0]  gap;
    logic [QW-1:0]  own_param;
    logic [QW-1:0]  other_param;
  } result_t;

  function automatic logic signed [PRW-1:0] mul_diff(input diff_t x, input diff_t y);
    logic signed [PRW-1:0] px;
    logic signed [PRW-1:0] py;
    px = PRW'(x);
    py = PRW'(y);
    return px * py;
  endfunction

  // clamp(num/den) to [0,1]: trivial outcomes finish here
  function automatic div_t div_init(input wide_t num, input wide_t den);
    div_t r;
    r.rem  = {1'b0, num};
    r.den  = den;
    r.q    = '0;
    r.done = 1'b0;
    if (den <= 0 || num <= 0) begin
      r.done = 1'b1;
    end else if (num >= den) begin
      r.q    = PARAM_ONE;
      r.done = 1'b1;
    end
    return r;
  endfunction

  // one restoring quotient bit
  function automatic div_t div_step(input div_t d);
    div_t        r;
    logic [PW:0] dbl;
    r   = d;
    dbl = {d.rem[PW-1:0], 1'b0};
    if (!d.done) begin
      if (dbl >= {1'b0, d.den}) begin
        r.rem = dbl - {1'b0, d.den};
        r.q   = {d.q[QW-2:0], 1'b1};
      end else begin
        r.rem = dbl;
        r.q   = {d.q[QW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/ccov_if.sv
// valid/ready channel interfaces for tested capsules and overlap results
interface ccov_in_if
  import ccov_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] other_start_x;
  logic signed [CW-1:0] other_start_y;
  logic signed [CW-1:0] other_start_z;
  logic signed [CW-1:0] other_end_x;
  logic signed [CW-1:0] other_end_y;
  logic signed [CW-1:0] other_end_z;
  logic [RW-1:0]        other_radius;

  modport source (output valid, other_start_x, other_start_y, other_start_z,
                  output other_end_x, other_end_y, other_end_z, other_radius,
                  input ready);
  modport sink   (input valid, other_start_x, other_start_y, other_start_z,
                  input other_end_x, other_end_y, other_end_z, other_radius,
                  output ready);
endinterface

interface ccov_out_if
  import ccov_pkg::*;
();
  logic          valid;
  logic          ready;
  logic          overlap;
  logic [GW-1:0] gap_squared;
  logic [QW-1:0] own_param;
  logic [QW-1:0] other_param;

  modport source (output valid, overlap, gap_squared, own_param, other_param,
                  input ready);
  modport sink   (input valid, overlap, gap_squared, own_param, other_param,
                  output ready);
endinterface

// File: hdl/ccov_front.sv
// axis differences and the five dot products, three stages
module ccov_front
  import ccov_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  capsule_t      cap_i,
  input  point_t        own_start_i,
  input  point_t        own_end_i,
  input  logic [RW-1:0] own_radius_i,
  output logic          valid_o,
  output geo_t          geo_o,
  output coef_t         coef_o
);

  logic v1_q, v2_q, v3_q;
  geo_t geo1_q, geo2_q, geo3_q;
  geo_t geo1_d;
  coef_t coef3_q, coef3_d;
  logic signed [PRW-1:0] pa_q [3];
  logic signed [PRW-1:0] pe_q [3];
  logic signed [PRW-1:0] pb_q [3];
  logic signed [PRW-1:0] pc_q [3];
  logic signed [PRW-1:0] pf_q [3];

  always_comb begin
    geo1_d.d1.x = DW'(own_end_i.x) - DW'(own_start_i.x);
    geo1_d.d1.y = DW'(own_end_i.y) - DW'(own_start_i.y);
    geo1_d.d1.z = DW'(own_end_i.z) - DW'(own_start_i.z);
    geo1_d.d2.x = DW'(cap_i.end_p.x) - DW'(cap_i.start_p.x);
    geo1_d.d2.y = DW'(cap_i.end_p.y) - DW'(cap_i.start_p.y);
    geo1_d.d2.z = DW'(cap_i.end_p.z) - DW'(cap_i.start_p.z);
    geo1_d.rv.x = DW'(own_start_i.x) - DW'(cap_i.start_p.x);
    geo1_d.rv.y = DW'(own_start_i.y) - DW'(cap_i.start_p.y);
    geo1_d.rv.z = DW'(own_start_i.z) - DW'(cap_i.start_p.z);
    geo1_d.rsum = {1'b0, own_radius_i} + {1'b0, cap_i.radius};
  end

  always_comb begin
    coef3_d.a = DOTW'(pa_q[0]) + DOTW'(pa_q[1]) + DOTW'(pa_q[2]);
    coef3_d.e = DOTW'(pe_q[0]) + DOTW'(pe_q[1]) + DOTW'(pe_q[2]);
    coef3_d.b = DOTW'(pb_q[0]) + DOTW'(pb_q[1]) + DOTW'(pb_q[2]);
    coef3_d.c = DOTW'(pc_q[0]) + DOTW'(pc_q[1]) + DOTW'(pc_q[2]);
    coef3_d.f = DOTW'(pf_q[0]) + DOTW'(pf_q[1]) + DOTW'(pf_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo1_q   <= geo1_d;
      geo2_q   <= geo1_q;
      pa_q[0]  <= mul_diff(geo1_q.d1.x, geo1_q.d1.x);
      pa_q[1]  <= mul_diff(geo1_q.d1.y, geo1_q.d1.y);
      pa_q[2]  <= mul_diff(geo1_q.d1.z, geo1_q.d1.z);
      pe_q[0]  <= mul_diff(geo1_q.d2.x, geo1_q.d2.x);
      pe_q[1]  <= mul_diff(geo1_q.d2.y, geo1_q.d2.y);
      pe_q[2]  <= mul_diff(geo1_q.d2.z, geo1_q.d2.z);
      pb_q[0]  <= mul_diff(geo1_q.d1.x, geo1_q.d2.x);
      pb_q[1]  <= mul_diff(geo1_q.d1.y, geo1_q.d2.y);
      pb_q[2]  <= mul_diff(geo1_q.d1.z, geo1_q.d2.z);
      pc_q[0]  <= mul_diff(geo1_q.d1.x, geo1_q.rv.x);
      pc_q[1]  <= mul_diff(geo1_q.d1.y, geo1_q.rv.y);
      pc_q[2]  <= mul_diff(geo1_q.d1.z, geo1_q.rv.z);
      pf_q[0]  <= mul_diff(geo1_q.d2.x, geo1_q.rv.x);
      pf_q[1]  <= mul_diff(geo1_q.d2.y, geo1_q.rv.y);
      pf_q[2]  <= mul_diff(geo1_q.d2.z, geo1_q.rv.z);
      geo3_q   <= geo2_q;
      coef3_q  <= coef3_d;
    end
  end

  assign valid_o = v3_q;
  assign geo_o   = geo3_q;
  assign coef_o  = coef3_q;

endmodule

// File: hdl/ccov_solve.sv
// closest point parameters: three-stage wide multiplier and two pipelined restoring dividers
module ccov_mul
  import ccov_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  dot_t  a_i,
  input  dot_t  b_i,
  output wide_t p_o
);

  logic signed [ML:0]       al [MLN];
  logic signed [ML:0]       bl [MLN];
  logic signed [2*ML+1:0]   pp_q [MLN][MLN];
  wide_t                    row_q [MLN];
  wide_t                    p_q;

  // low limbs unsigned, top limb carries the sign
  always_comb begin
    for (int i = 0; i < MLN; i++) begin
      al[i] = {1'b0, a_i[ML*i +: ML]};
      bl[i] = {1'b0, b_i[ML*i +: ML]};
    end
    al[MLN-1] = {a_i[DOTW-1], a_i[DOTW-1 -: ML]};
    bl[MLN-1] = {b_i[DOTW-1], b_i[DOTW-1 -: ML]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < MLN; i++) begin
        for (int j = 0; j < MLN; j++) begin
          pp_q[i][j] <= al[i] * bl[j];
        end
        row_q[i] <= PW'(pp_q[i][0]) + (PW'(pp_q[i][1]) <<< ML)
                    + (PW'(pp_q[i][2]) <<< (2 * ML));
      end
      p_q <= row_q[0] + (row_q[1] <<< ML) + (row_q[2] <<< (2 * ML));
    end
  end

  assign p_o = p_q;

endmodule

module ccov_solve
  import ccov_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  geo_t          geo_i,
  input  coef_t         coef_i,
  output logic          valid_o,
  output geo_t          geo_o,
  output logic [QW-1:0] s_o,
  output logic [QW-1:0] t_o
);

  // product stages
  logic  pv_q    [3];
  geo_t  pgeo_q  [3];
  coef_t pcoef_q [3];
  wide_t ae_p, bb_p, bf_p, ce_p;

  // first divider, index 0 is its init stage
  logic  sv_q    [PB+1];
  geo_t  sgeo_q  [PB+1];
  coef_t scoef_q [PB+1];
  div_t  sdiv_q  [PB+1];

  // t numerator stages
  logic          mv_q    [3];
  geo_t          mgeo_q  [3];
  coef_t         mcoef_q [3];
  logic [QW-1:0] ms_q    [3];
  wide_t         bs_p;
  logic          v22_q;
  geo_t          geo22_q;
  coef_t         coef22_q;
  logic [QW-1:0] s1_q;
  wide_t         tnum_q;

  // second divider
  logic          tv_q    [PB+1];
  geo_t          tgeo_q  [PB+1];
  div_t          tdiv_q  [PB+1];
  logic          tto_s_q [PB+1];
  logic [QW-1:0] tfix_s_q[PB+1];
  logic [QW-1:0] tfix_t_q[PB+1];

  wide_t         num2, den2, eone;
  logic          to_s_d;
  logic [QW-1:0] fix_s_d, fix_t_d;
  logic          a_zero, e_zero;

  ccov_mul u_ae (.clk_i(clk_i), .en_i(en_i), .a_i(coef_i.a), .b_i(coef_i.e), .p_o(ae_p));
  ccov_mul u_bb (.clk_i(clk_i), .en_i(en_i), .a_i(coef_i.b), .b_i(coef_i.b), .p_o(bb_p));
  ccov_mul u_bf (.clk_i(clk_i), .en_i(en_i), .a_i(coef_i.b), .b_i(coef_i.f), .p_o(bf_p));
  ccov_mul u_ce (.clk_i(clk_i), .en_i(en_i), .a_i(coef_i.c), .b_i(coef_i.e), .p_o(ce_p));
  ccov_mul u_bs (.clk_i(clk_i), .en_i(en_i), .a_i(scoef_q[PB].b),
                 .b_i(DOTW'(sdiv_q[PB].q)), .p_o(bs_p));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0]  <= 1'b0;
      pv_q[1]  <= 1'b0;
      pv_q[2]  <= 1'b0;
      sv_q[0]  <= 1'b0;
      mv_q[0]  <= 1'b0;
      mv_q[1]  <= 1'b0;
      mv_q[2]  <= 1'b0;
      v22_q    <= 1'b0;
      tv_q[0]  <= 1'b0;
    end else if (en_i) begin
      pv_q[0]  <= valid_i;
      pv_q[1]  <= pv_q[0];
      pv_q[2]  <= pv_q[1];
      sv_q[0]  <= pv_q[2];
      mv_q[0]  <= sv_q[PB];
      mv_q[1]  <= mv_q[0];
      mv_q[2]  <= mv_q[1];
      v22_q    <= mv_q[2];
      tv_q[0]  <= v22_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pgeo_q[0]  <= geo_i;
      pcoef_q[0] <= coef_i;
      pgeo_q[1]  <= pgeo_q[0];
      pcoef_q[1] <= pcoef_q[0];
      pgeo_q[2]  <= pgeo_q[1];
      pcoef_q[2] <= pcoef_q[1];
      sgeo_q[0]  <= pgeo_q[2];
      scoef_q[0] <= pcoef_q[2];
      // parallel axes give a zero denominator and so s = 0
      sdiv_q[0]  <= div_init(bf_p - ce_p, ae_p - bb_p);
      mgeo_q[0]  <= sgeo_q[PB];
      mcoef_q[0] <= scoef_q[PB];
      ms_q[0]    <= sdiv_q[PB].q;
      mgeo_q[1]  <= mgeo_q[0];
      mcoef_q[1] <= mcoef_q[0];
      ms_q[1]    <= ms_q[0];
      mgeo_q[2]  <= mgeo_q[1];
      mcoef_q[2] <= mcoef_q[1];
      ms_q[2]    <= ms_q[1];
      geo22_q    <= mgeo_q[2];
      coef22_q   <= mcoef_q[2];
      s1_q       <= ms_q[2];
      tnum_q     <= bs_p + (PW'(mcoef_q[2].f) <<< PB);
      tgeo_q[0]  <= geo22_q;
      tdiv_q[0]  <= div_init(num2, den2);
      tto_s_q[0] <= to_s_d;
      tfix_s_q[0] <= fix_s_d;
      tfix_t_q[0] <= fix_t_d;
    end
  end

  for (genvar k = 0; k < PB; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
        tv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[k+1] <= sv_q[k];
        tv_q[k+1] <= tv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sgeo_q[k+1]   <= sgeo_q[k];
        scoef_q[k+1]  <= scoef_q[k];
        sdiv_q[k+1]   <= div_step(sdiv_q[k]);
        tgeo_q[k+1]   <= tgeo_q[k];
        tdiv_q[k+1]   <= div_step(tdiv_q[k]);
        tto_s_q[k+1]  <= tto_s_q[k];
        tfix_s_q[k+1] <= tfix_s_q[k];
        tfix_t_q[k+1] <= tfix_t_q[k];
      end
    end
  end

  // pick the second quotient and which parameter it lands in
  always_comb begin
    a_zero  = (coef22_q.a == '0);
    e_zero  = (coef22_q.e == '0);
    eone    = PW'(coef22_q.e) <<< PB;
    num2    = PW'(coef22_q.f);
    den2    = PW'(coef22_q.e);
    to_s_d  = 1'b0;
    fix_s_d = '0;
    fix_t_d = '0;
    if (a_zero) begin
      num2 = PW'(coef22_q.f);
      den2 = PW'(coef22_q.e);
    end else if (e_zero) begin
      num2   = -PW'(coef22_q.c);
      den2   = PW'(coef22_q.a);
      to_s_d = 1'b1;
    end else if (tnum_q < 0) begin
      num2   = -PW'(coef22_q.c);
      den2   = PW'(coef22_q.a);
      to_s_d = 1'b1;
    end else if (tnum_q > eone) begin
      num2    = PW'(coef22_q.b) - PW'(coef22_q.c);
      den2    = PW'(coef22_q.a);
      to_s_d  = 1'b1;
      fix_t_d = PARAM_ONE;
    end else begin
      num2    = tnum_q;
      den2    = eone;
      fix_s_d = s1_q;
    end
  end

  assign valid_o = tv_q[PB];
  assign geo_o   = tgeo_q[PB];
  assign s_o     = tto_s_q[PB] ? tdiv_q[PB].q : tfix_s_q[PB];
  assign t_o     = tto_s_q[PB] ? tfix_t_q[PB] : tdiv_q[PB].q;

  a_s_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> s_o <= PARAM_ONE)
    else $error("own parameter above one");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> t_o <= PARAM_ONE)
    else $error("other parameter above one");

  a_point_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && geo_o.d1 == '0) |-> s_o == '0)
    else $error("point axis with nonzero own parameter");

endmodule

// File: hdl/ccov_dist.sv
// closest point distance, radius limit compare and output register
module ccov_dist
  import ccov_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  geo_t          geo_i,
  input  logic [QW-1:0] s_i,
  input  logic [QW-1:0] t_i,
  output logic          valid_o,
  output result_t       res_o
);

  localparam int LIMW = 2 * RSW + GAP_LSB;

  logic vA_q, vB_q, vD_q, vE_q;
  logic mv_q [3];
  logic signed [DVW-1:0] ma_q [3];
  logic signed [DVW-1:0] mb_q [3];
  logic signed [DVW-1:0] rs_q [3];
  logic signed [DVW-1:0] dv_q [3];
  wide_t sq_p [3];
  logic [2*RSW-1:0] rsqA_q, rsqB_q;
  logic [2*RSW-1:0] mrsq_q [3];
  logic [LIMW-1:0] lim_q;
  logic [SUMW-1:0] sum_q;
  logic [QW-1:0] sA_q, tA_q, sB_q, tB_q, sD_q, tD_q;
  logic [QW-1:0] ms_q [3];
  logic [QW-1:0] mt_q [3];
  logic signed [DVW-1:0] sx, tx;
  result_t res_q, res_d;

  assign sx = DVW'($signed({1'b0, s_i}));
  assign tx = DVW'($signed({1'b0, t_i}));

  for (genvar i = 0; i < 3; i++) begin : g_sq
    ccov_mul u_sq (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (DOTW'(dv_q[i])),
      .b_i   (DOTW'(dv_q[i])),
      .p_o   (sq_p[i])
    );
  end

  always_comb begin
    res_d.overlap     = (sum_q <= SUMW'(lim_q));
    res_d.gap         = (|sum_q[SUMW-1:GAP_LSB+GW]) ? {GW{1'b1}}
                        : sum_q[GAP_LSB+GW-1:GAP_LSB];
    res_d.own_param   = sD_q;
    res_d.other_param = tD_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q    <= 1'b0;
      vB_q    <= 1'b0;
      mv_q[0] <= 1'b0;
      mv_q[1] <= 1'b0;
      mv_q[2] <= 1'b0;
      vD_q    <= 1'b0;
      vE_q    <= 1'b0;
    end else if (en_i) begin
      vA_q    <= valid_i;
      vB_q    <= vA_q;
      mv_q[0] <= vB_q;
      mv_q[1] <= mv_q[0];
      mv_q[2] <= mv_q[1];
      vD_q    <= mv_q[2];
      vE_q    <= vD_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q[0] <= DVW'(geo_i.d1.x) * sx;
      ma_q[1] <= DVW'(geo_i.d1.y) * sx;
      ma_q[2] <= DVW'(geo_i.d1.z) * sx;
      mb_q[0] <= DVW'(geo_i.d2.x) * tx;
      mb_q[1] <= DVW'(geo_i.d2.y) * tx;
      mb_q[2] <= DVW'(geo_i.d2.z) * tx;
      rs_q[0] <= DVW'(geo_i.rv.x) <<< PB;
      rs_q[1] <= DVW'(geo_i.rv.y) <<< PB;
      rs_q[2] <= DVW'(geo_i.rv.z) <<< PB;
      rsqA_q  <= (2*RSW)'(geo_i.rsum) * (2*RSW)'(geo_i.rsum);
      sA_q    <= s_i;
      tA_q    <= t_i;
      for (int i = 0; i < 3; i++) begin
        dv_q[i] <= rs_q[i] + ma_q[i] - mb_q[i];
      end
      rsqB_q    <= rsqA_q;
      sB_q      <= sA_q;
      tB_q      <= tA_q;
      mrsq_q[0] <= rsqB_q;
      ms_q[0]   <= sB_q;
      mt_q[0]   <= tB_q;
      mrsq_q[1] <= mrsq_q[0];
      ms_q[1]   <= ms_q[0];
      mt_q[1]   <= mt_q[0];
      mrsq_q[2] <= mrsq_q[1];
      ms_q[2]   <= ms_q[1];
      mt_q[2]   <= mt_q[1];
      sum_q   <= SUMW'(sq_p[0]) + SUMW'(sq_p[1]) + SUMW'(sq_p[2]);
      lim_q   <= {mrsq_q[2], {GAP_LSB{1'b0}}};
      sD_q    <= ms_q[2];
      tD_q    <= mt_q[2];
      res_q   <= res_d;
    end
  end

  assign valid_o = vE_q;
  assign res_o   = res_q;

endmodule

// File: hdl/capsule_capsule_overlap.sv
// capsule-capsule overlap test: fixed capsule in registers against a stream of capsules
//
//   channel   direction  payload
//   in_if     sink       other_start_x/y/z, other_end_x/y/z, other_radius
//   out_if    source     overlap, gap_squared, own_param, other_param
//   cfg_*     input      cfg_we_i, cfg_idx_i, cfg_data_i (own capsule registers)
//
// one transaction per cycle while the output is not stalled; a result passes through
// the 3 dot product stages, two 16-step quotient dividers plus 9 stages of
// three-stage wide products and setup around them, and 7 distance stages
// (three of them the squaring multipliers) ending in the output register.
// reset clears the valid bits of every stage and the capsule registers.
// a stalled output freezes the whole pipeline, in ready follows it.
module capsule_capsule_overlap
  import ccov_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  ccov_in_if.sink         in_if,
  ccov_out_if.source      out_if,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [CW-1:0]   cfg_data_i
);

  point_t        own_start_q, own_end_q;
  logic [RW-1:0] own_radius_q;
  logic          en;
  capsule_t      cap;
  logic          fr_valid, sv_valid, out_valid;
  geo_t          fr_geo, sv_geo;
  coef_t         fr_coef;
  logic [QW-1:0] sv_s, sv_t;
  result_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_start_q  <= '0;
      own_end_q    <= '0;
      own_radius_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OWN_START_X: own_start_q.x <= cfg_data_i;
        REG_OWN_START_Y: own_start_q.y <= cfg_data_i;
        REG_OWN_START_Z: own_start_q.z <= cfg_data_i;
        REG_OWN_END_X:   own_end_q.x   <= cfg_data_i;
        REG_OWN_END_Y:   own_end_q.y   <= cfg_data_i;
        REG_OWN_END_Z:   own_end_q.z   <= cfg_data_i;
        REG_OWN_RADIUS:  own_radius_q  <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_valid || out_if.ready;
  assign in_if.ready = en;

  assign cap.start_p.x = in_if.other_start_x;
  assign cap.start_p.y = in_if.other_start_y;
  assign cap.start_p.z = in_if.other_start_z;
  assign cap.end_p.x   = in_if.other_end_x;
  assign cap.end_p.y   = in_if.other_end_y;
  assign cap.end_p.z   = in_if.other_end_z;
  assign cap.radius    = in_if.other_radius;

  ccov_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_if.valid),
    .cap_i        (cap),
    .own_start_i  (own_start_q),
    .own_end_i    (own_end_q),
    .own_radius_i (own_radius_q),
    .valid_o      (fr_valid),
    .geo_o        (fr_geo),
    .coef_o       (fr_coef)
  );

  ccov_solve u_solve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .geo_i   (fr_geo),
    .coef_i  (fr_coef),
    .valid_o (sv_valid),
    .geo_o   (sv_geo),
    .s_o     (sv_s),
    .t_o     (sv_t)
  );

  ccov_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_valid),
    .geo_i   (sv_geo),
    .s_i     (sv_s),
    .t_i     (sv_t),
    .valid_o (out_valid),
    .res_o   (res)
  );

  assign out_if.valid       = out_valid;
  assign out_if.overlap     = res.overlap;
  assign out_if.gap_squared = res.gap;
  assign out_if.own_param   = res.own_param;
  assign out_if.other_param = res.other_param;

endmodule
